### rtl/stt_pkg.sv
// Shared types and constants of the source text tokenizer.
package stt_pkg;

    // Port field widths.
    localparam int KIND_W = 6;
    localparam int OFF_W  = 24;
    localparam int LINE_W = 20;

    // Most tokens that one request can produce.
    localparam int MAX_RES = 4;
    localparam int RES_CNT_W = 3;

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [OFF_W-1:0]  off_t;
    typedef logic [LINE_W-1:0] line_t;

    // One token as it leaves the block.
    typedef struct packed {
        kind_t kind;
        off_t  start_offset;
        off_t  length;
        line_t line_number;
    } tok_t;

    // The tokens produced by one request, in order, and how many are valid.
    typedef struct packed {
        logic [RES_CNT_W-1:0]    count;
        tok_t [MAX_RES-1:0]      tok;
    } res_set_t;

    // Token kinds.
    localparam kind_t K_DOT    = 6'd5;
    localparam kind_t K_EQ     = 6'd12;
    localparam kind_t K_EQEQ   = 6'd13;
    localparam kind_t K_ARROW  = 6'd14;
    localparam kind_t K_BANG   = 6'd15;
    localparam kind_t K_BANGEQ = 6'd16;
    localparam kind_t K_LT     = 6'd17;
    localparam kind_t K_LE     = 6'd18;
    localparam kind_t K_GT     = 6'd19;
    localparam kind_t K_GE     = 6'd20;
    localparam kind_t K_STRING = 6'd21;
    localparam kind_t K_NUMBER = 6'd22;
    localparam kind_t K_IDENT  = 6'd23;
    localparam kind_t K_KW0    = 6'd24;
    localparam kind_t K_END    = 6'd32;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_EQ         = "=";
    localparam logic [7:0] CH_BANG       = "!";
    localparam logic [7:0] CH_LT         = "<";
    localparam logic [7:0] CH_GT         = ">";
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_NL         = 8'h0A;
    localparam logic [7:0] CH_DOT        = ".";
    localparam logic [7:0] CH_0          = "0";
    localparam logic [7:0] CH_9          = "9";
    localparam logic [7:0] CH_LA         = "a";
    localparam logic [7:0] CH_LZ         = "z";
    localparam logic [7:0] CH_UA         = "A";
    localparam logic [7:0] CH_UZ         = "Z";
    localparam logic [7:0] CH_UNDERSCORE = "_";

    // Single-character punctuation; the position in the list is the kind.
    localparam int NUM_PUNCT = 12;
    localparam int PUNCT_IDX_W = 4;
    localparam logic [7:0] PUNCT_CHARS [NUM_PUNCT] = '{
        "(", ")", "{", "}", ",", ".", ";", "+", "-", "*", "/", "~"
    };

    // Keywords, right-aligned and zero-filled; the position adds to K_KW0.
    localparam int NUM_KW = 8;
    localparam int KW_MAX_BITS = 128;
    localparam logic [KW_MAX_BITS-1:0] KW_TEXT [NUM_KW] = '{
        "var", "cli", "logicstream", "on", "event", "if", "else", "math"
    };

endpackage

### rtl/stt_core.sv
// Scanner state and the single-pass token decode for one request.
module stt_core #(
    parameter int OFFSET_BITS   = 24,
    parameter int LINE_BITS     = 20,
    parameter int KEYWORD_CHARS = 11
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         ch,
    input  logic               has_char,
    input  logic               last,
    input  logic               accept,
    output stt_pkg::res_set_t  results
);

    localparam int KW_BITS = KEYWORD_CHARS * 8;
    localparam int NUM_CAND = 6;

    typedef logic [OFFSET_BITS-1:0] pos_t;
    typedef logic [LINE_BITS-1:0]   lnum_t;
    typedef logic [KW_BITS-1:0]     word_t;

    typedef enum logic [9:0] {
        M_IDLE   = 10'b00_0000_0001,
        M_EQ     = 10'b00_0000_0010,
        M_BANG   = 10'b00_0000_0100,
        M_LT     = 10'b00_0000_1000,
        M_GT     = 10'b00_0001_0000,
        M_STR    = 10'b00_0010_0000,
        M_NUM    = 10'b00_0100_0000,
        M_NUMDOT = 10'b00_1000_0000,
        M_FRAC   = 10'b01_0000_0000,
        M_WORD   = 10'b10_0000_0000
    } mode_t;

    mode_t mode_reg, mode_next;
    pos_t  pos_reg, pos_next;
    pos_t  ts_reg, ts_next;
    lnum_t line_reg, line_next;
    word_t pf_reg, pf_next;
    logic  ov_reg, ov_next;

    // Intermediate state after the byte and the candidate tokens.
    mode_t m1;
    pos_t  ts1, pos1, p, d;
    lnum_t ln1;
    word_t pf1;
    logic  ov1, idle_go, hit;
    logic [stt_pkg::PUNCT_IDX_W-1:0] pidx;
    logic [NUM_CAND-1:0] cv;
    stt_pkg::tok_t ct [NUM_CAND];
    logic [stt_pkg::RES_CNT_W-1:0] n;

    function automatic pos_t inc_sat(pos_t v);
        return (v == '1) ? v : v + pos_t'(1);
    endfunction

    function automatic lnum_t line_up(lnum_t v);
        return (v == '1) ? v : v + lnum_t'(1);
    endfunction

    function automatic pos_t span(pos_t from, pos_t to);
        return (to >= from) ? to - from : '0;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= stt_pkg::CH_0) && (c <= stt_pkg::CH_9);
    endfunction

    function automatic logic is_word_start(logic [7:0] c);
        return ((c >= stt_pkg::CH_LA) && (c <= stt_pkg::CH_LZ))
            || ((c >= stt_pkg::CH_UA) && (c <= stt_pkg::CH_UZ))
            || (c == stt_pkg::CH_UNDERSCORE);
    endfunction

    function automatic stt_pkg::tok_t mk(stt_pkg::kind_t k, pos_t s, pos_t len, lnum_t ln);
        stt_pkg::tok_t t;
        t.kind         = k;
        t.start_offset = stt_pkg::off_t'(s);
        t.length       = stt_pkg::off_t'(len);
        t.line_number  = stt_pkg::line_t'(ln);
        return t;
    endfunction

    function automatic stt_pkg::kind_t op_single(mode_t m);
        stt_pkg::kind_t k;
        unique case (m)
            M_EQ:    k = stt_pkg::K_EQ;
            M_BANG:  k = stt_pkg::K_BANG;
            M_LT:    k = stt_pkg::K_LT;
            default: k = stt_pkg::K_GT;
        endcase
        return k;
    endfunction

    function automatic stt_pkg::kind_t op_pair(mode_t m);
        stt_pkg::kind_t k;
        unique case (m)
            M_EQ:    k = stt_pkg::K_EQEQ;
            M_BANG:  k = stt_pkg::K_BANGEQ;
            M_LT:    k = stt_pkg::K_LE;
            default: k = stt_pkg::K_GE;
        endcase
        return k;
    endfunction

    // A word too long for any keyword, or one matching none, is an identifier.
    function automatic stt_pkg::kind_t word_kind(word_t pf, logic ov);
        stt_pkg::kind_t k;
        k = stt_pkg::K_IDENT;
        if (!ov) begin
            for (int i = 0; i < stt_pkg::NUM_KW; i++) begin
                if (pf == stt_pkg::KW_TEXT[i][KW_BITS-1:0]) begin
                    k = stt_pkg::K_KW0 + stt_pkg::kind_t'(i);
                end
            end
        end
        return k;
    endfunction

    // Decode the byte, then the end-of-text flush, then pack the tokens.
    always_comb
    begin
        m1      = mode_reg;
        ts1     = ts_reg;
        ln1     = line_reg;
        pf1     = pf_reg;
        ov1     = ov_reg;
        pos1    = pos_reg;
        p       = pos_reg;
        d       = '0;
        idle_go = 1'b0;
        hit     = 1'b0;
        pidx    = '0;
        cv      = '0;
        for (int i = 0; i < NUM_CAND; i++) begin
            ct[i] = '0;
        end

        // Byte phase: close or extend the pending token.
        if (has_char) begin
            unique case (mode_reg)
                M_IDLE:
                begin
                    idle_go = 1'b1;
                end
                M_STR:
                begin
                    if (ch == stt_pkg::CH_QUOTE) begin
                        cv[0] = 1'b1;
                        ct[0] = mk(stt_pkg::K_STRING, ts_reg, span(ts_reg, p), line_reg);
                        m1    = M_IDLE;
                    end else if (ch == stt_pkg::CH_NL) begin
                        ln1 = line_up(line_reg);
                    end
                end
                M_EQ, M_BANG, M_LT, M_GT:
                begin
                    m1    = M_IDLE;
                    cv[0] = 1'b1;
                    if (ch == stt_pkg::CH_EQ) begin
                        ct[0] = mk(op_pair(mode_reg), ts_reg, pos_t'(2), line_reg);
                    end else if (mode_reg == M_EQ && ch == stt_pkg::CH_GT) begin
                        ct[0] = mk(stt_pkg::K_ARROW, ts_reg, pos_t'(2), line_reg);
                    end else begin
                        ct[0]   = mk(op_single(mode_reg), ts_reg, pos_t'(1), line_reg);
                        idle_go = 1'b1;
                    end
                end
                M_NUM, M_FRAC:
                begin
                    if (is_digit(ch)) begin
                        m1 = mode_reg;
                    end else if (mode_reg == M_NUM && ch == stt_pkg::CH_DOT) begin
                        m1 = M_NUMDOT;
                    end else begin
                        cv[0]   = 1'b1;
                        ct[0]   = mk(stt_pkg::K_NUMBER, ts_reg, span(ts_reg, p), line_reg);
                        m1      = M_IDLE;
                        idle_go = 1'b1;
                    end
                end
                M_NUMDOT:
                begin
                    if (is_digit(ch)) begin
                        m1 = M_FRAC;
                    end else begin
                        d       = (p != '0) ? p - pos_t'(1) : '0;
                        cv[0]   = 1'b1;
                        ct[0]   = mk(stt_pkg::K_NUMBER, ts_reg, span(ts_reg, d), line_reg);
                        cv[1]   = 1'b1;
                        ct[1]   = mk(stt_pkg::K_DOT, d, pos_t'(1), line_reg);
                        m1      = M_IDLE;
                        idle_go = 1'b1;
                    end
                end
                M_WORD:
                begin
                    if (is_word_start(ch) || is_digit(ch)) begin
                        ov1 = ov_reg | (pf_reg[KW_BITS-1 -: 8] != 8'h00);
                        pf1 = {pf_reg[KW_BITS-9:0], ch};
                    end else begin
                        cv[0]   = 1'b1;
                        ct[0]   = mk(word_kind(pf_reg, ov_reg), ts_reg, span(ts_reg, p),
                                     line_reg);
                        m1      = M_IDLE;
                        idle_go = 1'b1;
                    end
                end
                default:
                begin
                    idle_go = 1'b1;
                end
            endcase

            // The byte starts something new from the idle state.
            if (idle_go) begin
                for (int i = 0; i < stt_pkg::NUM_PUNCT; i++) begin
                    if (ch == stt_pkg::PUNCT_CHARS[i]) begin
                        hit  = 1'b1;
                        pidx = stt_pkg::PUNCT_IDX_W'(i);
                    end
                end
                if (hit) begin
                    cv[2] = 1'b1;
                    ct[2] = mk(stt_pkg::kind_t'(pidx), p, pos_t'(1), line_reg);
                end else begin
                    ts1 = p;
                    priority if (ch == stt_pkg::CH_EQ) begin
                        m1 = M_EQ;
                    end else if (ch == stt_pkg::CH_BANG) begin
                        m1 = M_BANG;
                    end else if (ch == stt_pkg::CH_LT) begin
                        m1 = M_LT;
                    end else if (ch == stt_pkg::CH_GT) begin
                        m1 = M_GT;
                    end else if (ch == stt_pkg::CH_QUOTE) begin
                        m1  = M_STR;
                        ts1 = inc_sat(p);
                    end else if (ch == stt_pkg::CH_NL) begin
                        ln1 = line_up(line_reg);
                    end else if (is_digit(ch)) begin
                        m1 = M_NUM;
                    end else if (is_word_start(ch)) begin
                        m1  = M_WORD;
                        pf1 = word_t'(ch);
                        ov1 = 1'b0;
                    end else begin
                        m1 = M_IDLE;
                    end
                end
            end
            pos1 = inc_sat(pos_reg);
        end

        // Flush phase: end of text closes the pending token, then the end token.
        if (last) begin
            unique case (m1)
                M_EQ, M_BANG, M_LT, M_GT:
                begin
                    cv[3] = 1'b1;
                    ct[3] = mk(op_single(m1), ts1, pos_t'(1), ln1);
                end
                M_NUM, M_FRAC:
                begin
                    cv[3] = 1'b1;
                    ct[3] = mk(stt_pkg::K_NUMBER, ts1, span(ts1, pos1), ln1);
                end
                M_NUMDOT:
                begin
                    d     = (pos1 != '0) ? pos1 - pos_t'(1) : '0;
                    cv[3] = 1'b1;
                    ct[3] = mk(stt_pkg::K_NUMBER, ts1, span(ts1, d), ln1);
                    cv[4] = 1'b1;
                    ct[4] = mk(stt_pkg::K_DOT, d, pos_t'(1), ln1);
                end
                M_WORD:
                begin
                    cv[3] = 1'b1;
                    ct[3] = mk(word_kind(pf1, ov1), ts1, span(ts1, pos1), ln1);
                end
                default:
                begin
                    cv[3] = 1'b0;
                end
            endcase
            cv[5] = 1'b1;
            ct[5] = mk(stt_pkg::K_END, pos1, '0, ln1);
        end

        // Pack the valid candidates, in order, into the result slots.
        n       = '0;
        results = '0;
        for (int i = 0; i < NUM_CAND; i++) begin
            if (cv[i]) begin
                if (n < stt_pkg::RES_CNT_W'(stt_pkg::MAX_RES)) begin
                    results.tok[n[1:0]] = ct[i];
                end
                n = n + stt_pkg::RES_CNT_W'(1);
            end
        end
        results.count = (n > stt_pkg::RES_CNT_W'(stt_pkg::MAX_RES))
                      ? stt_pkg::RES_CNT_W'(stt_pkg::MAX_RES) : n;
    end

    // Next scanner state; the end of the text restarts the scanner.
    always_comb
    begin
        if (last) begin
            mode_next = M_IDLE;
            pos_next  = '0;
            ts_next   = '0;
            line_next = lnum_t'(1);
            pf_next   = '0;
            ov_next   = 1'b0;
        end else begin
            mode_next = m1;
            pos_next  = pos1;
            ts_next   = ts1;
            line_next = ln1;
            pf_next   = pf1;
            ov_next   = ov1;
        end
    end

    // Scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_IDLE;
            pos_reg  <= '0;
            ts_reg   <= '0;
            line_reg <= lnum_t'(1);
            pf_reg   <= '0;
            ov_reg   <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            ts_reg   <= ts_next;
            line_reg <= line_next;
            pf_reg   <= pf_next;
            ov_reg   <= ov_next;
        end
    end

endmodule

### rtl/stt_resq.sv
// Result register that holds the tokens of one request and hands them out one by one.
module stt_resq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  stt_pkg::res_set_t  results,
    input  logic               out_ready,
    output logic               out_valid,
    output stt_pkg::tok_t      tok,
    output logic               run_end,
    output logic               can_load
);

    logic [stt_pkg::RES_CNT_W-1:0] rem_reg, rem_next;
    logic [1:0]                    head_reg, head_next;
    stt_pkg::tok_t                 res_reg [stt_pkg::MAX_RES];
    logic                          out_fire;

    assign out_valid = (rem_reg != '0);
    assign out_fire  = out_valid && out_ready;
    assign tok       = res_reg[head_reg];
    assign run_end   = (rem_reg == stt_pkg::RES_CNT_W'(1));

    // A new request may enter once the last held token leaves this cycle.
    assign can_load  = (rem_reg == '0) || (run_end && out_ready);

    // Remaining count and read pointer.
    always_comb
    begin
        rem_next  = rem_reg;
        head_next = head_reg;
        if (load) begin
            rem_next  = results.count;
            head_next = '0;
        end else if (out_fire) begin
            rem_next  = rem_reg - stt_pkg::RES_CNT_W'(1);
            head_next = head_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rem_reg  <= '0;
            head_reg <= '0;
        end else begin
            rem_reg  <= rem_next;
            head_reg <= head_next;
        end
    end

    // Token payload.
    always_ff @(posedge clk)
    begin
        if (load) begin
            for (int i = 0; i < stt_pkg::MAX_RES; i++) begin
                res_reg[i] <= results.tok[i];
            end
        end
    end

endmodule

### rtl/source_text_tokenizer_top.sv
// Top level of the source text tokenizer: scanner plus token output register.
//
// Usage: source bytes enter on the src channel (src_valid/src_ready), one byte
// per request in ch with has_char set; a request with last set ends the text,
// flushes any pending token and adds an end token. Tokens leave on the tok
// channel (tok_valid/tok_ready) as kind, start_offset, length and line_number;
// run_end marks the last token caused by one request.
// The tokens of a request appear in the cycle after it is accepted.
// Throughput: one request per cycle while each request yields at most one token
// and tok_ready is high; a request yielding more (up to four) holds the output
// register, which hands them out one token per cycle while tok_ready is high and
// takes a new request only in the cycle its last token leaves. The scanner itself
// decodes each byte combinationally, whether it ends a token or is only absorbed.
// Reset: scanner returns to offset 0, line 1 with nothing pending; the output
// register is empty. The same restart happens after every request with last.
// Stall: while tok_ready is low the held tokens stay put and src_ready is low
// unless the output register is empty; a request is also taken as the last token leaves.
module source_text_tokenizer_top #(
    parameter int OFFSET_BITS   = 24,
    parameter int LINE_BITS     = 20,
    parameter int KEYWORD_CHARS = 11
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_ready,
    input  logic [7:0]  ch,
    input  logic        has_char,
    input  logic        last,
    output logic        tok_valid,
    input  logic        tok_ready,
    output logic [5:0]  kind,
    output logic [23:0] start_offset,
    output logic [23:0] length,
    output logic [19:0] line_number,
    output logic        run_end
);

    logic              accept;
    stt_pkg::res_set_t results;
    stt_pkg::tok_t     tok;

    assign accept = src_valid && src_ready;

    // Byte decode and scanner state.
    stt_core #(
        .OFFSET_BITS   (OFFSET_BITS),
        .LINE_BITS     (LINE_BITS),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .ch       (ch),
        .has_char (has_char),
        .last     (last),
        .accept   (accept),
        .results  (results)
    );

    // Token output register.
    stt_resq u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .results   (results),
        .out_ready (tok_ready),
        .out_valid (tok_valid),
        .tok       (tok),
        .run_end   (run_end),
        .can_load  (src_ready)
    );

    assign kind         = tok.kind;
    assign start_offset = tok.start_offset;
    assign length       = tok.length;
    assign line_number  = tok.line_number;

endmodule
